[sv/sru_pkg.sv]
package sru_pkg;

   localparam int unsigned OperandWidth = 16;
   localparam int unsigned ClWidth      = 8;
   localparam int unsigned AmtWidth     = 5;

   // Shifts by more than this many places give the same answer as this.
   localparam logic [AmtWidth-1:0] ShiftClamp = 5'd17;
   // Rotate-through-carry lengths (operand plus carry) for the two widths.
   localparam logic [AmtWidth-1:0] RclLenWide = 5'd17;
   localparam logic [AmtWidth-1:0] RclLenByte = 5'd9;

   typedef enum logic [2:0] {
      OP_ROL   = 3'd0,
      OP_ROR   = 3'd1,
      OP_RCL   = 3'd2,
      OP_RCR   = 3'd3,
      OP_SHL   = 3'd4,
      OP_SHR   = 3'd5,
      OP_SETMO = 3'd6,
      OP_SAR   = 3'd7
   } op_type;

   // One captured request beat.
   typedef struct packed {
      op_type                  opcode;
      logic                    wide;
      logic                    use_cl;
      logic [OperandWidth-1:0] operand;
      logic [ClWidth-1:0]      cl_count;
      logic                    carry_in;
      logic                    aux_in;
   } req_type;

   // Count reduced to the amounts each operation class needs.
   typedef struct packed {
      logic                is_zero;
      logic                cl_zero;
      logic [3:0]          rot_amt;
      logic [AmtWidth-1:0] rcl_amt;
      logic [AmtWidth-1:0] sh_amt;
   } cnt_type;

   // One response beat.
   typedef struct packed {
      logic [OperandWidth-1:0] result;
      logic                    carry_out;
      logic                    overflow_out;
      logic                    sign_out;
      logic                    zero_out;
      logic                    parity_out;
      logic                    aux_out;
      logic                    carry_overflow_written;
      logic                    arith_flags_written;
   } rsp_type;

endpackage

[sv/shift_rotate_unit_8_16_core.sv]
// Group-2 shift/rotate unit for an 8086-style execute stage. Each request
// beat carries one ROL/ROR/RCL/RCR/SHL/SHR/SETMO/SAR on an 8- or 16-bit
// operand with a count of one or CL (0..255, not masked). The response beat
// carries the result, CF/OF/SF/ZF/PF/AF and two write marks saying which
// flags the instruction updates; unwritten flags come back as CF and AF
// passed through, the rest zero. A request beat passes through one capture
// register, then a single-pass barrel shifter with flag logic into the
// response register. Throughput is one beat per clock; the only
// back-pressure is rsp_stall, and a request is still taken while a finished
// response waits as long as the capture register is empty.
module shift_rotate_unit_8_16_core import sru_pkg::*; (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic        req_wide,
   input  logic        req_use_cl,
   input  logic [15:0] req_operand,
   input  logic [7:0]  req_cl_count,
   input  logic        req_carry_in,
   input  logic        req_aux_in,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_result,
   output logic        rsp_carry_out,
   output logic        rsp_overflow_out,
   output logic        rsp_sign_out,
   output logic        rsp_zero_out,
   output logic        rsp_parity_out,
   output logic        rsp_aux_out,
   output logic        rsp_carry_overflow_written,
   output logic        rsp_arith_flags_written
);

   // Capture stage
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_ff, s1_in;

   // Response stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic    out_free;   // response register can take a beat this cycle
   logic    s1_free;    // capture register can take a beat this cycle
   logic    req_fire;

   cnt_type cnt;
   rsp_type calc;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_free   = !s1_valid_ff || out_free;
   assign req_stall = !s1_free;
   assign req_fire  = req_valid && s1_free;

   always_comb begin
      s1_valid_in = s1_free ? req_valid : s1_valid_ff;
      s1_in       = s1_ff;
      if (req_fire) begin
         s1_in.opcode   = op_type'(req_opcode);
         s1_in.wide     = req_wide;
         s1_in.use_cl   = req_use_cl;
         s1_in.operand  = req_operand;
         s1_in.cl_count = req_cl_count;
         s1_in.carry_in = req_carry_in;
         s1_in.aux_in   = req_aux_in;
      end
   end

   // Count reduction: mod width for rotates, mod width+1 through carry,
   // clamp for shifts.
   sru_count u_count (
      .req (s1_ff),
      .cnt (cnt)
   );

   // Barrel shifter plus flag generation.
   sru_shifter u_shifter (
      .req (s1_ff),
      .cnt (cnt),
      .rsp (calc)
   );

   always_comb begin
      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
      rsp_in       = (out_free && s1_valid_ff) ? calc : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset needed.
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_result                 = rsp_ff.result;
   assign rsp_carry_out              = rsp_ff.carry_out;
   assign rsp_overflow_out           = rsp_ff.overflow_out;
   assign rsp_sign_out               = rsp_ff.sign_out;
   assign rsp_zero_out               = rsp_ff.zero_out;
   assign rsp_parity_out             = rsp_ff.parity_out;
   assign rsp_aux_out                = rsp_ff.aux_out;
   assign rsp_carry_overflow_written = rsp_ff.carry_overflow_written;
   assign rsp_arith_flags_written    = rsp_ff.arith_flags_written;

`ifndef SYNTHESIS
   // Arithmetic flags are only written together with CF/OF.
   a_arith_implies_co: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.arith_flags_written |-> rsp_ff.carry_overflow_written)
      else $error("arith flags written without carry/overflow");

   // Unwritten SF/ZF/PF read back as zero.
   a_unwritten_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.arith_flags_written
         |-> !rsp_ff.sign_out && !rsp_ff.zero_out && !rsp_ff.parity_out)
      else $error("unwritten arithmetic flag not zero");

   // A blocked response must not let the captured beat drop out.
   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && rsp_stall |=> s1_valid_ff && $stable(s1_ff))
      else $error("capture stage lost a beat under stall");
`endif

endmodule

[sv/sru_count.sv]
module sru_count import sru_pkg::*; (
   input  req_type req,
   output cnt_type cnt
);

   logic [ClWidth-1:0]  count;
   logic [AmtWidth-1:0] diff17;
   logic [AmtWidth-1:0] mod17;
   logic [6:0]          fold64;
   logic [AmtWidth-1:0] diff9;
   logic [AmtWidth-1:0] mod9;

   assign count = req.use_cl ? req.cl_count : 8'd1;

   // mod 17: 16 == -1, so low nibble minus high nibble.
   assign diff17 = {1'b0, count[3:0]} - {1'b0, count[7:4]};
   assign mod17  = diff17[AmtWidth-1] ? diff17 + RclLenWide : diff17;

   // mod 9: 64 == 1, fold to <= 66; then 8 == -1 on the folded value.
   assign fold64 = {5'd0, count[7:6]} + {1'b0, count[5:0]};
   assign diff9  = {2'd0, fold64[2:0]} - {1'b0, fold64[6:3]};
   assign mod9   = diff9[AmtWidth-1] ? diff9 + RclLenByte : diff9;

   always_comb begin
      cnt.is_zero = (count == '0);
      cnt.cl_zero = req.use_cl && (req.cl_count == '0);
      cnt.rot_amt = req.wide ? count[3:0] : {1'b0, count[2:0]};
      cnt.rcl_amt = req.wide ? mod17 : mod9;
      cnt.sh_amt  = (count > {3'd0, ShiftClamp}) ? ShiftClamp : count[AmtWidth-1:0];
   end

endmodule

[sv/sru_shifter.sv]
module sru_shifter import sru_pkg::*; (
   input  req_type req,
   input  cnt_type cnt,
   output rsp_type rsp
);

   logic [15:0] v;
   logic [7:0]  v8;
   logic [15:0] mask;

   logic [31:0] rol16, ror16;
   logic [15:0] rol8, ror8;
   logic [33:0] rcl17, rcr17;
   logic [17:0] rcl9, rcr9;
   logic [32:0] shl;
   logic [16:0] shr;
   logic [15:0] sar_src;
   logic [16:0] sar;

   logic [15:0] res;
   logic        cf;
   logic        msb;
   logic        nmsb;

   assign v8   = req.operand[7:0];
   assign v    = req.wide ? req.operand : {8'd0, v8};
   assign mask = req.wide ? 16'hFFFF : 16'h00FF;

   assign rol16 = {v, v} << cnt.rot_amt;
   assign ror16 = {v, v} >> cnt.rot_amt;
   assign rol8  = {v8, v8} << cnt.rot_amt[2:0];
   assign ror8  = {v8, v8} >> cnt.rot_amt[2:0];

   // Carry sits above the operand; rotate the (width+1)-bit ring.
   assign rcl17 = {req.carry_in, v, req.carry_in, v} << cnt.rcl_amt;
   assign rcr17 = {req.carry_in, v, req.carry_in, v} >> cnt.rcl_amt;
   assign rcl9  = {req.carry_in, v8, req.carry_in, v8} << cnt.rcl_amt;
   assign rcr9  = {req.carry_in, v8, req.carry_in, v8} >> cnt.rcl_amt;

   assign shl     = {17'd0, v} << cnt.sh_amt;
   assign shr     = {v, 1'b0} >> cnt.sh_amt;
   assign sar_src = req.wide ? v : {{8{v8[7]}}, v8};
   assign sar     = 17'($signed({sar_src, 1'b0}) >>> cnt.sh_amt);

   always_comb begin
      res = v;
      cf  = req.carry_in;
      case (req.opcode)
         OP_ROL: begin
            res = req.wide ? rol16[31:16] : {8'd0, rol8[15:8]};
            cf  = res[0];
         end
         OP_ROR: begin
            res = req.wide ? ror16[15:0] : {8'd0, ror8[7:0]};
            cf  = req.wide ? res[15] : res[7];
         end
         OP_RCL: begin
            res = req.wide ? rcl17[32:17] : {8'd0, rcl9[16:9]};
            cf  = req.wide ? rcl17[33] : rcl9[17];
         end
         OP_RCR: begin
            res = req.wide ? rcr17[15:0] : {8'd0, rcr9[7:0]};
            cf  = req.wide ? rcr17[16] : rcr9[8];
         end
         OP_SHL: begin
            res = shl[15:0] & mask;
            cf  = req.wide ? shl[16] : shl[8];
         end
         OP_SHR: begin
            res = shr[16:1];
            cf  = shr[0];
         end
         OP_SAR: begin
            res = sar[16:1] & mask;
            cf  = sar[0];
         end
         default: begin
            res = v;
            cf  = req.carry_in;
         end
      endcase
   end

   assign msb  = req.wide ? res[15] : res[7];
   assign nmsb = req.wide ? res[14] : res[6];

   always_comb begin
      rsp.result                 = v;
      rsp.carry_out              = req.carry_in;
      rsp.overflow_out           = 1'b0;
      rsp.sign_out               = 1'b0;
      rsp.zero_out               = 1'b0;
      rsp.parity_out             = 1'b0;
      rsp.aux_out                = req.aux_in;
      rsp.carry_overflow_written = 1'b0;
      rsp.arith_flags_written    = 1'b0;
      if (req.opcode == OP_SETMO) begin
         rsp.result = cnt.cl_zero ? 16'd0 : mask;
      end else if (!cnt.is_zero) begin
         rsp.result                 = res;
         rsp.carry_out              = cf;
         rsp.carry_overflow_written = 1'b1;
         if (req.opcode == OP_ROL || req.opcode == OP_RCL || req.opcode == OP_SHL) begin
            rsp.overflow_out = msb ^ cf;
         end else begin
            rsp.overflow_out = msb ^ nmsb;
         end
         if (req.opcode == OP_SHL || req.opcode == OP_SHR || req.opcode == OP_SAR) begin
            rsp.arith_flags_written = 1'b1;
            rsp.sign_out            = msb;
            rsp.zero_out            = (res == 16'd0);
            rsp.parity_out          = ~^res[7:0];
            rsp.aux_out             = (req.opcode == OP_SHL) ? (req.aux_in | res[4]) : 1'b0;
         end
      end
   end

endmodule

[tb/shift_rotate_checker.sv]
// Watches both channels of the shift/rotate unit, predicts each response
// beat from the accepted request beat, and compares the two in order.
module shift_rotate_checker import sru_pkg::*; (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic        req_wide,
   input  logic        req_use_cl,
   input  logic [15:0] req_operand,
   input  logic [7:0]  req_cl_count,
   input  logic        req_carry_in,
   input  logic        req_aux_in,

   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_result,
   input  logic        rsp_carry_out,
   input  logic        rsp_overflow_out,
   input  logic        rsp_sign_out,
   input  logic        rsp_zero_out,
   input  logic        rsp_parity_out,
   input  logic        rsp_aux_out,
   input  logic        rsp_carry_overflow_written,
   input  logic        rsp_arith_flags_written,

   output int          mismatch_total,
   output int          beats_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   rsp_type expected_beats[$];
   req_type seen_req;
   rsp_type seen_rsp;
   rsp_type want_rsp;
   int      errors = 0;

   // Bit-serial equivalent of the barrel shifter: count single-bit steps.
   function automatic rsp_type predict_shift_rotate(input req_type rq);
      logic [15:0] mask;
      logic [15:0] msb;
      logic [15:0] nmsb;
      logic [15:0] v;
      logic        cf;
      logic        af;
      logic        ob;
      logic        left;
      int unsigned cnt;
      int unsigned step;
      rsp_type     r;

      mask = rq.wide ? 16'hFFFF : 16'h00FF;
      msb  = rq.wide ? 16'h8000 : 16'h0080;
      nmsb = rq.wide ? 16'h4000 : 16'h0040;
      v    = rq.operand & mask;
      cf   = rq.carry_in;
      af   = rq.aux_in;
      cnt  = rq.use_cl ? rq.cl_count : 1;
      left = (rq.opcode == OP_ROL) || (rq.opcode == OP_RCL) || (rq.opcode == OP_SHL);
      r    = '0;

      if (rq.opcode == OP_SETMO) begin
         v = (rq.use_cl && rq.cl_count == 8'd0) ? 16'h0000 : mask;
      end else if (cnt != 0) begin
         for (step = 0; step < cnt; step++) begin
            ob = left ? |(v & msb) : v[0];
            case (rq.opcode)
               OP_ROL:  v = ((v << 1) | {15'd0, ob}) & mask;
               OP_ROR:  v = (v >> 1) | (ob ? msb : 16'h0000);
               OP_RCL:  v = ((v << 1) | {15'd0, cf}) & mask;
               OP_RCR:  v = (v >> 1) | (cf ? msb : 16'h0000);
               OP_SHL:  v = (v << 1) & mask;
               OP_SHR:  v = v >> 1;
               default: v = (v >> 1) | (v & msb);
            endcase
            cf = ob;
         end
         r.carry_overflow_written = 1'b1;
         if (left)
            r.overflow_out = (|(v & msb)) ^ cf;
         else
            r.overflow_out = (|(v & msb)) ^ (|(v & nmsb));
         if ((rq.opcode == OP_SHL) || (rq.opcode == OP_SHR) || (rq.opcode == OP_SAR)) begin
            r.arith_flags_written = 1'b1;
            r.sign_out   = |(v & msb);
            r.zero_out   = (v == 16'h0000);
            r.parity_out = ~^v[7:0];
            af = (rq.opcode == OP_SHL) ? (af | v[4]) : 1'b0;
         end
      end

      r.result    = v;
      r.carry_out = cf;
      r.aux_out   = af;
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen_req.opcode   = op_type'(req_opcode);
            seen_req.wide     = req_wide;
            seen_req.use_cl   = req_use_cl;
            seen_req.operand  = req_operand;
            seen_req.cl_count = req_cl_count;
            seen_req.carry_in = req_carry_in;
            seen_req.aux_in   = req_aux_in;
            expected_beats.push_back(predict_shift_rotate(seen_req));
         end
         if (rsp_valid && !rsp_stall) begin
            seen_rsp.result                 = rsp_result;
            seen_rsp.carry_out              = rsp_carry_out;
            seen_rsp.overflow_out           = rsp_overflow_out;
            seen_rsp.sign_out               = rsp_sign_out;
            seen_rsp.zero_out               = rsp_zero_out;
            seen_rsp.parity_out             = rsp_parity_out;
            seen_rsp.aux_out                = rsp_aux_out;
            seen_rsp.carry_overflow_written = rsp_carry_overflow_written;
            seen_rsp.arith_flags_written    = rsp_arith_flags_written;
            if (expected_beats.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("[%0t] response beat with nothing expected: result=%h", $realtime,
                           rsp_result);
            end else begin
               want_rsp = expected_beats.pop_front();
               if (seen_rsp !== want_rsp) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("[%0t] mismatch exp: res=%h cf=%b of=%b sf=%b zf=%b",
                              $realtime, want_rsp.result, want_rsp.carry_out,
                              want_rsp.overflow_out, want_rsp.sign_out, want_rsp.zero_out);
                     $display("                   pf=%b af=%b cow=%b arw=%b",
                              want_rsp.parity_out, want_rsp.aux_out,
                              want_rsp.carry_overflow_written, want_rsp.arith_flags_written);
                     $display("              got: res=%h cf=%b of=%b sf=%b zf=%b",
                              seen_rsp.result, seen_rsp.carry_out, seen_rsp.overflow_out,
                              seen_rsp.sign_out, seen_rsp.zero_out);
                     $display("                   pf=%b af=%b cow=%b arw=%b",
                              seen_rsp.parity_out, seen_rsp.aux_out,
                              seen_rsp.carry_overflow_written,
                              seen_rsp.arith_flags_written);
                  end
               end
            end
         end
      end
      mismatch_total  <= errors;
      beats_in_flight <= expected_beats.size();
   end

endmodule

[tb/tb_shift_rotate_unit_8_16_core.sv]
// Top of the shift/rotate unit testbench. It makes the clock, the reset and
// the stimulus, and gives the verdict; all prediction and comparison lives
// in shift_rotate_checker, which hands back a mismatch count and the number
// of response beats still owed.
module tb_shift_rotate_unit_8_16_core import sru_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // Far above the slowest legal run of ~1900 beats.
   localparam int CycleLimit   = 200000;
   localparam int RandomPerPhase = 630;
   // Drain time after the last expected beat.
   localparam int DrainCycles  = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid    = 1'b0;
   logic        req_stall;
   logic [2:0]  req_opcode   = 3'd0;
   logic        req_wide     = 1'b0;
   logic        req_use_cl   = 1'b0;
   logic [15:0] req_operand  = 16'h0000;
   logic [7:0]  req_cl_count = 8'h00;
   logic        req_carry_in = 1'b0;
   logic        req_aux_in   = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall    = 1'b1;
   logic [15:0] rsp_result;
   logic        rsp_carry_out;
   logic        rsp_overflow_out;
   logic        rsp_sign_out;
   logic        rsp_zero_out;
   logic        rsp_parity_out;
   logic        rsp_aux_out;
   logic        rsp_carry_overflow_written;
   logic        rsp_arith_flags_written;

   int          mismatch_total;
   int          beats_in_flight;
   int          cycle_count   = 0;
   // Idle odds, in percent. Sender odds are only read by the stimulus
   // process; the stall odds are read by the receiver's always block.
   int          send_idle_pct = 6;
   int          rsp_stall_pct = 56;

   always #5 clock = ~clock;

   shift_rotate_unit_8_16_core dut (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_stall                  (req_stall),
      .req_opcode                 (req_opcode),
      .req_wide                   (req_wide),
      .req_use_cl                 (req_use_cl),
      .req_operand                (req_operand),
      .req_cl_count               (req_cl_count),
      .req_carry_in               (req_carry_in),
      .req_aux_in                 (req_aux_in),
      .rsp_valid                  (rsp_valid),
      .rsp_stall                  (rsp_stall),
      .rsp_result                 (rsp_result),
      .rsp_carry_out              (rsp_carry_out),
      .rsp_overflow_out           (rsp_overflow_out),
      .rsp_sign_out               (rsp_sign_out),
      .rsp_zero_out               (rsp_zero_out),
      .rsp_parity_out             (rsp_parity_out),
      .rsp_aux_out                (rsp_aux_out),
      .rsp_carry_overflow_written (rsp_carry_overflow_written),
      .rsp_arith_flags_written    (rsp_arith_flags_written)
   );

   shift_rotate_checker checker_i (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_stall                  (req_stall),
      .req_opcode                 (req_opcode),
      .req_wide                   (req_wide),
      .req_use_cl                 (req_use_cl),
      .req_operand                (req_operand),
      .req_cl_count               (req_cl_count),
      .req_carry_in               (req_carry_in),
      .req_aux_in                 (req_aux_in),
      .rsp_valid                  (rsp_valid),
      .rsp_stall                  (rsp_stall),
      .rsp_result                 (rsp_result),
      .rsp_carry_out              (rsp_carry_out),
      .rsp_overflow_out           (rsp_overflow_out),
      .rsp_sign_out               (rsp_sign_out),
      .rsp_zero_out               (rsp_zero_out),
      .rsp_parity_out             (rsp_parity_out),
      .rsp_aux_out                (rsp_aux_out),
      .rsp_carry_overflow_written (rsp_carry_overflow_written),
      .rsp_arith_flags_written    (rsp_arith_flags_written),
      .mismatch_total             (mismatch_total),
      .beats_in_flight            (beats_in_flight)
   );

   // Receiver back-pressure: a fresh coin toss every cycle.
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // One request beat: optional idle cycles first, then hold the payload
   // until the core takes it. req_valid is written once per edge at most,
   // so back-to-back beats keep it high.
   task automatic drive_beat(input op_type op, input logic wd, input logic ucl,
                             input logic [15:0] opnd, input logic [7:0] cl,
                             input logic ci, input logic ai);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_wide     <= wd;
      req_use_cl   <= ucl;
      req_operand  <= opnd;
      req_cl_count <= cl;
      req_carry_in <= ci;
      req_aux_in   <= ai;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   // Random beat. Counts lean small so results stay interesting, with the
   // full CL range now and then; operands sometimes sit on edge patterns.
   task automatic drive_random_beat();
      op_type      op;
      logic [15:0] opnd;
      logic [7:0]  cl;
      logic        ucl;

      op  = op_type'($urandom_range(7));
      ucl = ($urandom_range(3) != 0);
      cl  = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(20));
      case ($urandom_range(9))
         0:       opnd = 16'h0000;
         1:       opnd = 16'hFFFF;
         2:       opnd = 16'h8000;
         3:       opnd = 16'h0080;
         default: opnd = 16'($urandom);
      endcase
      drive_beat(op, 1'($urandom_range(1)), ucl, opnd, cl, 1'($urandom_range(1)),
                 1'($urandom_range(1)));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Phase one: light sender idling, heavy receiver stall.
      send_idle_pct = 6;

      // Directed: every op, count one, 16-bit, both end bits set.
      for (int k = 0; k < 8; k++)
         drive_beat(op_type'(k), 1'b1, 1'b0, 16'h8001, 8'h00, 1'b1, 1'b0);
      // Every op, 8-bit, largest CL; upper byte junk must be ignored.
      for (int k = 0; k < 8; k++)
         drive_beat(op_type'(k), 1'b0, 1'b1, 16'hFF81, 8'hFF, 1'b0, 1'b1);
      // Zero count passes the operand, CF and AF through.
      drive_beat(OP_SHL, 1'b1, 1'b1, 16'hFFFF, 8'h00, 1'b1, 1'b1);
      // SETMO: zero when CL is zero, all ones otherwise (count of one too).
      drive_beat(OP_SETMO, 1'b0, 1'b1, 16'h1234, 8'h00, 1'b1, 1'b0);
      drive_beat(OP_SETMO, 1'b0, 1'b0, 16'h1234, 8'h00, 1'b0, 1'b1);
      // SAR keeps the sign bit across a full-width count.
      drive_beat(OP_SAR, 1'b1, 1'b1, 16'h8000, 8'd16, 1'b0, 1'b0);
      // SHL sets AF from result bit 4 on the byte path.
      drive_beat(OP_SHL, 1'b0, 1'b1, 16'h0008, 8'd1, 1'b0, 1'b0);
      // RCR the full 17-bit loop, carry in set.
      drive_beat(OP_RCR, 1'b1, 1'b1, 16'h5A5A, 8'd17, 1'b1, 1'b0);
      // Zero result from SHR, and SHL shifting everything out.
      drive_beat(OP_SHR, 1'b1, 1'b1, 16'h0001, 8'd1, 1'b0, 1'b1);
      drive_beat(OP_SHL, 1'b1, 1'b1, 16'hFFFF, 8'd16, 1'b0, 1'b1);

      repeat (RandomPerPhase) drive_random_beat();

      // Phase two: the other way round.
      send_idle_pct = 56;
      rsp_stall_pct <= 6;
      repeat (RandomPerPhase) drive_random_beat();

      // Phase three: full rate both sides.
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      repeat (RandomPerPhase) drive_random_beat();

      req_valid <= 1'b0;

      // Counts from the checker are registered, so step the clock before looking.
      @(posedge clock);
      while (beats_in_flight != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_total == 0 && beats_in_flight == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
